### rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// Shared types, byte constants and result codes of the template tag scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_PCT    = 8'h25;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		K_TEXT    = 2'd0,
		K_CONTENT = 2'd1,
		K_DONE    = 2'd2,
		K_ERROR   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic       tag_type;
		logic [7:0] char_out;
		logic       last;
	} res_t;

	// Results produced by one scanned byte: a count of zero to two and the slots.
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	typedef struct packed {
		logic failed;
	} core_stat_t;

endpackage

`default_nettype wire

### rtl/core/tts_in_if.sv
// ----------------------------------------------------------------------------
// tts_in_if
// Byte input channel: template byte and suppress flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       suppress;

	modport source (output valid, output char_in, output suppress, input ready);
	modport sink   (input valid, input char_in, input suppress, output ready);
endinterface

`default_nettype wire

### rtl/core/tts_out_if.sv
// ----------------------------------------------------------------------------
// tts_out_if
// Result output channel: kind, tag type, byte and last flag with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tts_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic       tag_type;
	logic [7:0] char_out;
	logic       last;

	modport source (output valid, output kind, output tag_type, output char_out,
		output last, input ready);
	modport sink   (input valid, input kind, input tag_type, input char_out,
		input last, output ready);
endinterface

`default_nettype wire

### rtl/core/tts_scan_core.sv
// ----------------------------------------------------------------------------
// tts_scan_core
// Scanner state machine: classifies one byte per step and emits up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_scan_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      ch,
	input  wire logic            sup,
	output tts_pkg::push_t       push,
	output tts_pkg::core_stat_t  stat
);

	typedef enum logic [2:0] {
		M_TEXT        = 3'd0,
		M_OPEN        = 3'd1,
		M_STRING      = 3'd2,
		M_COMMENT     = 3'd3,
		M_COMMENT_END = 3'd4,
		M_CLOSE       = 3'd5,
		M_STATEMENT   = 3'd6,
		M_EXPRESSION  = 3'd7
	} mode_t;

	mode_t mode_q, mode_d;
	logic  tag_kind_q, tag_kind_d;
	logic  quote_dbl_q, quote_dbl_d;
	logic  failed_q, failed_d;

	tts_pkg::res_t r0, r1;
	logic [1:0]    n;
	mode_t         tag_mode;
	logic [7:0]    closer;
	logic [7:0]    quote;

	function automatic tts_pkg::res_t mk(tts_pkg::kind_t k, logic t, logic [7:0] c);
		tts_pkg::res_t r;
		r.kind     = k;
		r.tag_type = t;
		r.char_out = c;
		r.last     = 1'b0;
		return r;
	endfunction

	always_comb begin
		tag_mode    = tag_kind_q ? M_STATEMENT : M_EXPRESSION;
		closer      = tag_kind_q ? tts_pkg::CH_PCT : tts_pkg::CH_RBRACE;
		quote       = quote_dbl_q ? tts_pkg::CH_DQUOTE : tts_pkg::CH_SQUOTE;
		mode_d      = mode_q;
		tag_kind_d  = tag_kind_q;
		quote_dbl_d = quote_dbl_q;
		failed_d    = failed_q;
		n           = 2'd0;
		r0          = mk(tts_pkg::K_TEXT, 1'b0, 8'h00);
		r1          = mk(tts_pkg::K_TEXT, 1'b0, 8'h00);
		if (!failed_q) begin
			if (ch == tts_pkg::CH_NL) begin
				if (mode_q != M_COMMENT) begin
					if (mode_q == M_TEXT) begin
						if (!sup) begin
							r0 = mk(tts_pkg::K_TEXT, 1'b0, ch);
							n  = 2'd1;
						end
					end else begin
						failed_d = 1'b1;
						if (sup) begin
							r0 = mk(tts_pkg::K_ERROR, 1'b0, 8'h00);
							n  = 2'd1;
						end else begin
							r0 = mk(tts_pkg::K_TEXT, 1'b0, ch);
							r1 = mk(tts_pkg::K_ERROR, 1'b0, 8'h00);
							n  = 2'd2;
						end
					end
				end
			end else begin
				unique case (mode_q)
					M_TEXT: begin
						if (ch == tts_pkg::CH_LBRACE) begin
							mode_d = M_OPEN;
						end else if (!sup) begin
							r0 = mk(tts_pkg::K_TEXT, 1'b0, ch);
							n  = 2'd1;
						end
					end
					M_OPEN: begin
						if (ch == tts_pkg::CH_PCT) begin
							mode_d     = M_STATEMENT;
							tag_kind_d = 1'b1;
						end else if (ch == tts_pkg::CH_LBRACE) begin
							if (sup) begin
								mode_d = M_TEXT;
							end else begin
								mode_d     = M_EXPRESSION;
								tag_kind_d = 1'b0;
							end
						end else if (ch == tts_pkg::CH_HASH) begin
							mode_d = M_COMMENT;
						end else begin
							// A lone brace turns out to be text and, unless suppressed, is flushed with this byte.
							mode_d = M_TEXT;
							if (!sup) begin
								r0 = mk(tts_pkg::K_TEXT, 1'b0, tts_pkg::CH_LBRACE);
								r1 = mk(tts_pkg::K_TEXT, 1'b0, ch);
								n  = 2'd2;
							end
						end
					end
					M_COMMENT: begin
						if (ch == tts_pkg::CH_HASH) begin
							mode_d = M_COMMENT_END;
						end
					end
					M_COMMENT_END: begin
						mode_d = (ch == tts_pkg::CH_RBRACE) ? M_TEXT : M_COMMENT;
					end
					M_STATEMENT, M_EXPRESSION: begin
						if (ch == closer) begin
							mode_d = M_CLOSE;
						end else begin
							if (ch == tts_pkg::CH_SQUOTE || ch == tts_pkg::CH_DQUOTE) begin
								quote_dbl_d = (ch == tts_pkg::CH_DQUOTE);
								mode_d      = M_STRING;
							end
							r0 = mk(tts_pkg::K_CONTENT, tag_kind_q, ch);
							n  = 2'd1;
						end
					end
					M_STRING: begin
						if (ch == quote) begin
							mode_d = tag_mode;
						end
						r0 = mk(tts_pkg::K_CONTENT, tag_kind_q, ch);
						n  = 2'd1;
					end
					M_CLOSE: begin
						if (ch == tts_pkg::CH_RBRACE) begin
							mode_d = M_TEXT;
							r0     = mk(tts_pkg::K_DONE, tag_kind_q, 8'h00);
							n      = 2'd1;
						end else begin
							// False closer: both bytes are content and the tag goes on.
							mode_d = tag_mode;
							r0     = mk(tts_pkg::K_CONTENT, tag_kind_q, closer);
							r1     = mk(tts_pkg::K_CONTENT, tag_kind_q, ch);
							n      = 2'd2;
						end
					end
					default: begin
						mode_d = M_TEXT;
					end
				endcase
			end
		end
		if (n == 2'd1) begin
			r0.last = 1'b1;
		end
		if (n == 2'd2) begin
			r1.last = 1'b1;
		end
		push.n    = step ? n : 2'd0;
		push.r0   = r0;
		push.r1   = r1;
		stat.failed = failed_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_TEXT;
			tag_kind_q  <= 1'b0;
			quote_dbl_q <= 1'b0;
			failed_q    <= 1'b0;
		end else if (step) begin
			mode_q      <= mode_d;
			tag_kind_q  <= tag_kind_d;
			quote_dbl_q <= quote_dbl_d;
			failed_q    <= failed_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/tts_result_queue.sv
// ----------------------------------------------------------------------------
// tts_result_queue
// Small result queue: takes up to two results a cycle, delivers one a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tts_result_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tts_pkg::push_t             push,
	input  wire logic                       pop,
	output tts_pkg::res_t                   head,
	output logic [tts_pkg::QCW-1:0]         count
);

	tts_pkg::res_t               entry_q [tts_pkg::QDEPTH];
	logic [tts_pkg::QAW-1:0]     wp_q, rp_q;
	logic [tts_pkg::QCW-1:0]     count_q;
	logic [tts_pkg::QAW-1:0]     wp_next1;

	assign wp_next1 = wp_q + tts_pkg::QAW'(1);
	assign head     = entry_q[rp_q];
	assign count    = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wp_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry_q[wp_next1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + tts_pkg::QAW'(push.n);
			rp_q    <= rp_q + tts_pkg::QAW'(pop);
			count_q <= count_q + tts_pkg::QCW'(push.n) - tts_pkg::QCW'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/core/template_tag_scanner_unit.sv
// ----------------------------------------------------------------------------
// template_tag_scanner_unit
// Template tag scanner: splits a byte stream into text, tag content and tag
// markers, with a registered input stage and a four-entry result queue.
// ----------------------------------------------------------------------------
// Flow: an accepted byte is held in the input stage and scanned once the result
// queue has room; its results are then offered from the head of the queue.
// Throughput: one byte per cycle while the queue has room; the output side
// gives one result per cycle while ready is high, so two-result bytes back up.
// The input stage scans a byte only when the result queue has room for two.
// Reset: arst_n clears the scanner to plain text mode and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module template_tag_scanner_unit (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tts_in_if.sink      bytes,
	tts_out_if.source   results
);

	logic                      valid_s1;
	logic [7:0]                char_s1;
	logic                      sup_s1;
	logic                      room;
	logic                      consume;
	logic                      pop;
	logic [tts_pkg::QCW-1:0]   count;
	tts_pkg::push_t            push;
	tts_pkg::core_stat_t       stat;
	tts_pkg::res_t             head;

	assign room        = (count <= tts_pkg::QCW'(tts_pkg::QDEPTH - 2));
	assign consume     = valid_s1 && room;
	assign bytes.ready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			char_s1 <= bytes.char_in;
			sup_s1  <= bytes.suppress;
		end
	end

	tts_scan_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (consume),
		.ch     (char_s1),
		.sup    (sup_s1),
		.push   (push),
		.stat   (stat)
	);

	assign pop = results.valid && results.ready;

	tts_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	assign results.valid    = (count != '0);
	assign results.kind     = head.kind;
	assign results.tag_type = head.tag_type;
	assign results.char_out = head.char_out;
	assign results.last     = head.last;

	// The queue never holds more than its depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= tts_pkg::QCW'(tts_pkg::QDEPTH))
		else $error("result queue overfilled");

	// A byte is scanned only when the queue can take both of its results.
	a_room_on_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> (count <= tts_pkg::QCW'(tts_pkg::QDEPTH - 2)))
		else $error("results pushed without room");

	// Once failed, the scanner produces nothing more.
	a_silent_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		stat.failed |-> (push.n == 2'd0))
		else $error("result produced after error");

	// A request held in the input stage stays until it is scanned.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(char_s1)))
		else $error("input stage lost a byte");

endmodule

`default_nettype wire

### tb/template_tag_scanner_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// template_tag_scanner_unit_checker
// Watches the request and result channels of the tag scanner, works out the
// results of every accepted request and compares them in order, field by
// field, with what the block returns.
// ----------------------------------------------------------------------------
module template_tag_scanner_unit_checker import tts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	tts_in_if    bytes,
	tts_out_if   results,
	output int   mismatches,
	output int   results_due_count,
	output int   bytes_seen,
	output int   results_seen,
	output int   tags_closed,
	output int   error_marks
);

	typedef enum logic [2:0] {
		SCAN_TEXT,
		SCAN_OPEN,
		SCAN_STRING,
		SCAN_COMMENT,
		SCAN_COMMENT_END,
		SCAN_CLOSE,
		SCAN_STATEMENT,
		SCAN_EXPRESSION
	} scan_mode_t;

	scan_mode_t mode;
	logic       in_statement;
	logic       double_quoted;
	logic       dead;
	res_t       results_due[$];
	res_t       want;

	function automatic res_t make_res(input kind_t k, input logic tt, input logic [7:0] ch);
		res_t r;
		r.kind     = k;
		r.tag_type = tt;
		r.char_out = ch;
		r.last     = 1'b0;
		return r;
	endfunction

	// Advances the scanner state by one byte and queues the results it causes.
	task automatic scan_byte(input logic [7:0] c, input logic sup);
		res_t       made[2];
		int         n;
		scan_mode_t tag_mode;
		logic [7:0] closer;
		logic [7:0] quote;
		n        = 0;
		tag_mode = in_statement ? SCAN_STATEMENT : SCAN_EXPRESSION;
		closer   = in_statement ? CH_PCT : CH_RBRACE;
		quote    = double_quoted ? CH_DQUOTE : CH_SQUOTE;
		if (dead)
			return;
		if (c == CH_NL) begin
			if (mode != SCAN_COMMENT) begin
				if (!sup) begin
					made[n] = make_res(K_TEXT, 1'b0, c);
					n++;
				end
				if (mode != SCAN_TEXT) begin
					made[n] = make_res(K_ERROR, 1'b0, 8'h00);
					n++;
					dead = 1'b1;
				end
			end
		end else begin
			case (mode)
				SCAN_TEXT: begin
					if (c == CH_LBRACE)
						mode = SCAN_OPEN;
					else if (!sup) begin
						made[n] = make_res(K_TEXT, 1'b0, c);
						n++;
					end
				end
				SCAN_OPEN: begin
					if (c == CH_PCT) begin
						mode         = SCAN_STATEMENT;
						in_statement = 1'b1;
					end else if (c == CH_LBRACE) begin
						if (sup)
							mode = SCAN_TEXT;
						else begin
							mode         = SCAN_EXPRESSION;
							in_statement = 1'b0;
						end
					end else if (c == CH_HASH) begin
						mode = SCAN_COMMENT;
					end else begin
						mode = SCAN_TEXT;
						if (!sup) begin
							made[0] = make_res(K_TEXT, 1'b0, CH_LBRACE);
							made[1] = make_res(K_TEXT, 1'b0, c);
							n       = 2;
						end
					end
				end
				SCAN_COMMENT: begin
					if (c == CH_HASH)
						mode = SCAN_COMMENT_END;
				end
				SCAN_COMMENT_END: begin
					mode = (c == CH_RBRACE) ? SCAN_TEXT : SCAN_COMMENT;
				end
				SCAN_STATEMENT, SCAN_EXPRESSION: begin
					if (c == closer)
						mode = SCAN_CLOSE;
					else begin
						if (c == CH_SQUOTE || c == CH_DQUOTE) begin
							double_quoted = (c == CH_DQUOTE);
							mode          = SCAN_STRING;
						end
						made[n] = make_res(K_CONTENT, in_statement, c);
						n++;
					end
				end
				SCAN_STRING: begin
					if (c == quote)
						mode = tag_mode;
					made[n] = make_res(K_CONTENT, in_statement, c);
					n++;
				end
				default: begin
					// A closer was seen; only '}' completes the tag, anything else
					// turns both bytes into content without looking at the second.
					if (c == CH_RBRACE) begin
						mode    = SCAN_TEXT;
						made[n] = make_res(K_DONE, in_statement, 8'h00);
						n++;
					end else begin
						mode    = tag_mode;
						made[0] = make_res(K_CONTENT, in_statement, closer);
						made[1] = make_res(K_CONTENT, in_statement, c);
						n       = 2;
					end
				end
			endcase
		end
		if (n > 0)
			made[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++)
			results_due.push_back(made[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode          = SCAN_TEXT;
			in_statement  = 1'b0;
			double_quoted = 1'b0;
			dead          = 1'b0;
			results_due.delete();
			mismatches    = 0;
			bytes_seen    = 0;
			results_seen  = 0;
			tags_closed   = 0;
			error_marks   = 0;
		end else begin
			if (bytes.valid && bytes.ready) begin
				bytes_seen++;
				scan_byte(bytes.char_in, bytes.suppress);
			end
			if (results.valid && results.ready) begin
				results_seen++;
				if (results.kind == K_DONE)
					tags_closed++;
				if (results.kind == K_ERROR)
					error_marks++;
				if (results_due.size() == 0) begin
					$error("unexpected result: kind %0d tag_type %0d char_out 0x%02h last %0d",
						results.kind, results.tag_type, results.char_out, results.last);
					mismatches++;
				end else begin
					want = results_due.pop_front();
					if (results.kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, results.kind);
						mismatches++;
					end
					if (results.tag_type !== want.tag_type) begin
						$error("tag_type: expected %0d, actual %0d", want.tag_type,
							results.tag_type);
						mismatches++;
					end
					if (results.char_out !== want.char_out) begin
						$error("char_out: expected 0x%02h, actual 0x%02h", want.char_out,
							results.char_out);
						mismatches++;
					end
					if (results.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, results.last);
						mismatches++;
					end
				end
			end
		end
		results_due_count = results_due.size();
	end

endmodule

### tb/template_tag_scanner_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// template_tag_scanner_unit_tb
// Drives template bytes into the tag scanner: a directed opening, then mostly
// well-formed text, tags and comments with random content, mixed with noise,
// under four idle mixes and one long output hold-off. The run closes with a
// newline outside text and comment mode, after which the block must stay silent.
// ----------------------------------------------------------------------------
module template_tag_scanner_unit_tb;
	import tts_pkg::*;

	localparam int CYCLE_LIMIT    = 200000;
	localparam int PHASE_REQUESTS = 440;
	localparam int HOLD_CYCLES    = 160;
	localparam int DRAIN_CYCLES   = 10;

	typedef enum int {
		FAIL_AFTER_BRACE,
		FAIL_IN_STRING,
		FAIL_AFTER_CLOSER,
		FAIL_IN_TAG,
		FAIL_AFTER_HASH
	} fail_case_t;

	logic clk      = 1'b0;
	logic arst_n   = 1'b0;
	logic hold_off = 1'b0;

	int send_idle_pct;
	int stall_pct;
	int sent;
	int cycles;
	int target;
	int idle_by_phase[4]  = '{0, 57, 0, 26};
	int stall_by_phase[4] = '{0, 0, 57, 26};

	int mismatches;
	int due_count;
	int bytes_seen;
	int results_seen;
	int tags_closed;
	int error_marks;

	bit [255:0] ban_text, ban_lone, ban_fill_expr, ban_fill_stmt, ban_str_sq, ban_str_dq;
	bit [255:0] ban_after_delim, ban_comment, ban_noise, ban_flush;

	tts_in_if  bytes_ch();
	tts_out_if results_ch();

	template_tag_scanner_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (bytes_ch),
		.results (results_ch)
	);

	template_tag_scanner_unit_checker u_chk (
		.clk               (clk),
		.arst_n            (arst_n),
		.bytes             (bytes_ch),
		.results           (results_ch),
		.mismatches        (mismatches),
		.results_due_count (due_count),
		.bytes_seen        (bytes_seen),
		.results_seen      (results_seen),
		.tags_closed       (tags_closed),
		.error_marks       (error_marks)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		results_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
	end

	// Long output hold-off while the sender keeps offering requests.
	initial begin
		wait (sent >= 80);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$error("timeout after %0d cycles with %0d results outstanding", cycles, due_count);
		$display("status: fail");
		$finish;
	end

	function automatic bit [255:0] ban(input logic [7:0] a, b, c, d);
		bit [255:0] m;
		m    = '0;
		m[a] = 1'b1;
		m[b] = 1'b1;
		m[c] = 1'b1;
		m[d] = 1'b1;
		return m;
	endfunction

	function automatic logic [7:0] pick(input bit [255:0] banned);
		logic [7:0] b;
		do b = 8'($urandom_range(255)); while (banned[b]);
		return b;
	endfunction

	function automatic bit chance(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	task automatic send(input logic [7:0] c, input logic sup);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			bytes_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bytes_ch.valid    <= 1'b1;
		bytes_ch.char_in  <= c;
		bytes_ch.suppress <= sup;
		@(posedge clk);
		while (!bytes_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	// Brings the scanner back to plain text from any state that quote-free,
	// hash-free bytes can reach.
	task automatic flush_to_text();
		send(pick(ban_flush), chance(50));
		send(CH_PCT, chance(50));
		send(CH_RBRACE, chance(50));
		send(CH_RBRACE, chance(50));
	endtask

	task automatic send_text();
		repeat ($urandom_range(1, 12))
			send(chance(10) ? CH_NL : pick(ban_text), chance(25));
	endtask

	task automatic send_tag(input bit stmt, input bit finish);
		logic [7:0] closer;
		logic [7:0] q;
		int         roll;
		closer = stmt ? CH_PCT : CH_RBRACE;
		send(CH_LBRACE, chance(50));
		if (stmt)
			send(CH_PCT, chance(50));
		else
			send(CH_LBRACE, 1'b0);
		repeat ($urandom_range(8)) begin
			roll = $urandom_range(99);
			if (roll < 15) begin
				q = chance(50) ? CH_DQUOTE : CH_SQUOTE;
				send(q, chance(25));
				repeat ($urandom_range(5))
					send(pick(q == CH_DQUOTE ? ban_str_dq : ban_str_sq), chance(25));
				send(q, chance(25));
			end else if (roll < 30) begin
				send(closer, chance(25));
				send(pick(ban_after_delim), chance(25));
			end else begin
				send(pick(stmt ? ban_fill_stmt : ban_fill_expr), chance(25));
			end
		end
		if (finish) begin
			send(closer, chance(25));
			send(CH_RBRACE, chance(25));
		end else begin
			flush_to_text();
		end
	endtask

	task automatic send_comment();
		send(CH_LBRACE, chance(50));
		send(CH_HASH, chance(50));
		repeat ($urandom_range(10)) begin
			if (chance(15)) begin
				send(CH_HASH, chance(50));
				send(pick(ban_after_delim), chance(50));
			end else begin
				send(chance(15) ? CH_NL : pick(ban_comment), chance(50));
			end
		end
		send(CH_HASH, chance(50));
		send(CH_RBRACE, chance(50));
	endtask

	task automatic send_segment();
		int roll;
		roll = $urandom_range(99);
		if (roll < 28)
			send_text();
		else if (roll < 36) begin
			send(CH_LBRACE, chance(50));
			send(pick(ban_lone), chance(40));
		end else if (roll < 40) begin
			send(CH_LBRACE, chance(50));
			send(CH_LBRACE, 1'b1);
		end else if (roll < 60)
			send_tag(1'b0, chance(92));
		else if (roll < 78)
			send_tag(1'b1, chance(92));
		else if (roll < 90)
			send_comment();
		else begin
			repeat ($urandom_range(1, 8))
				send(pick(ban_noise), chance(50));
			flush_to_text();
		end
	endtask

	// Puts the scanner in some state other than text or comment and feeds it a
	// newline; everything after that must be ignored.
	task automatic end_in_error();
		fail_case_t fc;
		fc = fail_case_t'($urandom_range(4));
		send(CH_LBRACE, 1'b0);
		case (fc)
			FAIL_IN_STRING: begin
				send(CH_PCT, 1'b0);
				send(chance(50) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
			end
			FAIL_AFTER_CLOSER: begin
				send(CH_PCT, 1'b0);
				send(CH_PCT, 1'b0);
			end
			FAIL_IN_TAG: begin
				send(CH_LBRACE, 1'b0);
				send(pick(ban_fill_expr), 1'b0);
			end
			FAIL_AFTER_HASH: begin
				send(CH_HASH, 1'b0);
				send(CH_HASH, 1'b0);
			end
			default: ;
		endcase
		send(CH_NL, chance(50));
		repeat (6)
			send(pick('0), chance(50));
	endtask

	initial begin
		bytes_ch.valid    = 1'b0;
		bytes_ch.char_in  = 8'h00;
		bytes_ch.suppress = 1'b0;
		results_ch.ready  = 1'b0;
		send_idle_pct     = 0;
		stall_pct         = 0;
		sent              = 0;

		ban_text        = ban(CH_LBRACE, CH_LBRACE, CH_LBRACE, CH_LBRACE);
		ban_lone        = ban(CH_LBRACE, CH_PCT, CH_HASH, CH_NL);
		ban_fill_expr   = ban(CH_NL, CH_SQUOTE, CH_DQUOTE, CH_RBRACE);
		ban_fill_stmt   = ban(CH_NL, CH_SQUOTE, CH_DQUOTE, CH_PCT);
		ban_str_sq      = ban(CH_NL, CH_SQUOTE, CH_SQUOTE, CH_SQUOTE);
		ban_str_dq      = ban(CH_NL, CH_DQUOTE, CH_DQUOTE, CH_DQUOTE);
		ban_after_delim = ban(CH_RBRACE, CH_NL, CH_NL, CH_NL);
		ban_comment     = ban(CH_HASH, CH_HASH, CH_HASH, CH_HASH);
		ban_noise       = ban(CH_NL, CH_SQUOTE, CH_DQUOTE, CH_HASH);
		ban_flush       = ban(CH_LBRACE, CH_PCT, CH_HASH, CH_NL)
			| ban(CH_SQUOTE, CH_DQUOTE, CH_SQUOTE, CH_DQUOTE);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Plain text at the byte extremes, with and without suppression.
		send(8'h00, 1'b0);
		send(8'hFF, 1'b1);
		send(CH_NL, 1'b0);
		send(CH_NL, 1'b1);
		// A lone brace, passed on and dropped, then a suppressed expression open.
		send(CH_LBRACE, 1'b0);
		send("A", 1'b0);
		send(CH_LBRACE, 1'b0);
		send("B", 1'b1);
		send(CH_LBRACE, 1'b0);
		send(CH_LBRACE, 1'b1);
		// Expression with closers inside a string and a false close.
		send(CH_LBRACE, 1'b0);
		send(CH_LBRACE, 1'b0);
		send(8'hFF, 1'b0);
		send(CH_SQUOTE, 1'b0);
		send(CH_RBRACE, 1'b0);
		send(CH_SQUOTE, 1'b0);
		send(CH_RBRACE, 1'b0);
		send("z", 1'b0);
		send(CH_RBRACE, 1'b0);
		send(CH_RBRACE, 1'b0);
		// Statement whose false close is followed by a quote that opens nothing.
		send(CH_LBRACE, 1'b0);
		send(CH_PCT, 1'b1);
		send(CH_PCT, 1'b0);
		send(CH_DQUOTE, 1'b0);
		send(CH_PCT, 1'b0);
		send(CH_RBRACE, 1'b0);
		// Comment with a newline and a stray hash inside.
		send(CH_LBRACE, 1'b0);
		send(CH_HASH, 1'b0);
		send(CH_NL, 1'b1);
		send(CH_HASH, 1'b0);
		send("q", 1'b0);
		send(CH_HASH, 1'b0);
		send(CH_RBRACE, 1'b0);

		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = idle_by_phase[phase];
			stall_pct     = stall_by_phase[phase];
			target        = sent + PHASE_REQUESTS;
			while (sent < target)
				send_segment();
		end
		send_idle_pct = 0;
		stall_pct     = 0;
		end_in_error();
		bytes_ch.valid <= 1'b0;

		@(posedge clk);
		while (due_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Scanned %0d requests into %0d results: %0d tags closed, %0d error marker(s).",
			bytes_seen, results_seen, tags_closed, error_marks);
		$display("Idle mixes: none, sender, receiver, both; one output hold-off of %0d cycles.",
			HOLD_CYCLES);
		if (due_count != 0)
			$error("%0d expected results never arrived", due_count);
		if (mismatches == 0 && due_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
